// ===== rtl/slt_pkg.sv =====
// Shared types and constants for the sorted list table.
// Depends on nothing; imported by slt_core, sorted_list_table_top and the testbench.
`default_nettype none

package slt_pkg;

    localparam int CAPACITY = 16;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int DATA_W   = 32;

    // request kinds
    localparam logic [1:0] KIND_INSERT = 2'd0;
    localparam logic [1:0] KIND_DELETE = 2'd1;
    localparam logic [1:0] KIND_SEARCH = 2'd2;

    // result status codes
    localparam logic [1:0] ST_DONE = 2'd0;
    localparam logic [1:0] ST_MISS = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    typedef struct packed {
        logic [1:0]               kind;
        logic signed [DATA_W-1:0] value;
    } req_beat_t;

    typedef struct packed {
        logic [1:0] status;
        logic [4:0] entry_count;
    } rsp_beat_t;

    // result handed from the engine to the output stage
    typedef struct packed {
        logic [1:0]       status;
        logic [CNT_W-1:0] count;
    } slt_res_t;

endpackage

`default_nettype wire

// ===== rtl/slt_core.sv =====
// Table memory and the walk engine that inserts, deletes and searches.
// Depends on slt_pkg.
`default_nettype none

module slt_core (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire slt_pkg::req_beat_t req,
    input  wire logic [slt_pkg::CNT_W-1:0] count,
    input  wire logic              res_ready,
    output logic                   busy,
    output logic                   fin,
    output slt_pkg::slt_res_t      res
);
    import slt_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_SCAN  = 4'b0010,
        S_PLACE = 4'b0100,
        S_FIN   = 4'b1000
    } state_t;

    state_t                   state_reg, state_next;
    logic [1:0]               kind_reg, kind_next;
    logic signed [DATA_W-1:0] value_reg, value_next;
    logic [IDX_W-1:0]         idx_reg, idx_next;
    logic                     found_reg, found_next;
    slt_res_t                 res_reg, res_next;

    logic signed [DATA_W-1:0] mem [CAPACITY];
    logic signed [DATA_W-1:0] rd_data_reg;
    logic [IDX_W-1:0]         rd_addr;
    logic                     wr_en;
    logic [IDX_W-1:0]         wr_addr;
    logic signed [DATA_W-1:0] wr_data;

    logic [CNT_W-1:0] cnt_m1;
    logic             last;
    logic             hit;

    assign cnt_m1 = count - CNT_W'(1);
    assign last   = (CNT_W'(idx_reg) + CNT_W'(1)) == count;
    assign hit    = rd_data_reg == value_reg;

    // Insert walks down from the top entry, delete and search walk up from
    // entry zero. Reads and writes in the same cycle of a walk always hit different entries.
    always_comb
    begin
        state_next = state_reg;
        kind_next  = kind_reg;
        value_next = value_reg;
        idx_next   = idx_reg;
        found_next = found_reg;
        res_next   = res_reg;
        rd_addr    = idx_reg;
        wr_en      = 1'b0;
        wr_addr    = idx_reg;
        wr_data    = value_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    kind_next      = req.kind;
                    value_next     = req.value;
                    found_next     = 1'b0;
                    res_next.count = count;
                    res_next.status = ST_MISS;
                    state_next     = S_FIN;
                    case (req.kind)
                        KIND_INSERT:
                        begin
                            if (count == CNT_W'(CAPACITY))
                            begin
                                res_next.status = ST_FULL;
                            end
                            else if (count == '0)
                            begin
                                wr_en           = 1'b1;
                                wr_addr         = '0;
                                wr_data         = req.value;
                                res_next.status = ST_DONE;
                                res_next.count  = count + CNT_W'(1);
                            end
                            else
                            begin
                                rd_addr    = cnt_m1[IDX_W-1:0];
                                idx_next   = cnt_m1[IDX_W-1:0];
                                state_next = S_SCAN;
                            end
                        end
                        KIND_DELETE, KIND_SEARCH:
                        begin
                            if (count != '0)
                            begin
                                rd_addr    = '0;
                                idx_next   = '0;
                                state_next = S_SCAN;
                            end
                        end
                        default:
                        begin
                            state_next = S_FIN;
                        end
                    endcase
                end
            end

            S_SCAN:
            begin
                if (kind_reg == KIND_INSERT)
                begin
                    wr_en   = 1'b1;
                    wr_addr = idx_reg + IDX_W'(1);
                    if (value_reg > rd_data_reg)
                    begin
                        wr_data         = value_reg;
                        res_next.status = ST_DONE;
                        res_next.count  = count + CNT_W'(1);
                        state_next      = S_FIN;
                    end
                    else
                    begin
                        // shift this entry up one slot
                        wr_data = rd_data_reg;
                        if (idx_reg == '0)
                        begin
                            res_next.status = ST_DONE;
                            res_next.count  = count + CNT_W'(1);
                            state_next      = S_PLACE;
                        end
                        else
                        begin
                            rd_addr  = idx_reg - IDX_W'(1);
                            idx_next = idx_reg - IDX_W'(1);
                        end
                    end
                end
                else if (kind_reg == KIND_DELETE)
                begin
                    // past the first match, every entry moves down one slot
                    if (found_reg)
                    begin
                        wr_en   = 1'b1;
                        wr_addr = idx_reg - IDX_W'(1);
                        wr_data = rd_data_reg;
                    end
                    found_next = found_reg | hit;
                    if (last)
                    begin
                        if (found_reg || hit)
                        begin
                            res_next.status = ST_DONE;
                            res_next.count  = count - CNT_W'(1);
                        end
                        else
                        begin
                            res_next.status = ST_MISS;
                        end
                        state_next = S_FIN;
                    end
                    else
                    begin
                        rd_addr  = idx_reg + IDX_W'(1);
                        idx_next = idx_reg + IDX_W'(1);
                    end
                end
                else
                begin
                    if (hit)
                    begin
                        res_next.status = ST_DONE;
                        state_next      = S_FIN;
                    end
                    else if (last)
                    begin
                        res_next.status = ST_MISS;
                        state_next      = S_FIN;
                    end
                    else
                    begin
                        rd_addr  = idx_reg + IDX_W'(1);
                        idx_next = idx_reg + IDX_W'(1);
                    end
                end
            end

            S_PLACE:
            begin
                wr_en      = 1'b1;
                wr_addr    = '0;
                wr_data    = value_reg;
                state_next = S_FIN;
            end

            S_FIN:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            found_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            found_reg <= found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg  <= kind_next;
        value_reg <= value_next;
        idx_reg   <= idx_next;
        res_reg   <= res_next;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign busy = (state_reg != S_IDLE);
    assign fin  = (state_reg == S_FIN);
    assign res  = res_reg;

    a_walk_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SCAN |-> CNT_W'(idx_reg) < count)
        else $error("walk index beyond stored entries");

    a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SCAN && wr_en |-> wr_addr != rd_addr)
        else $error("read and write hit the same entry");

    a_fin_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_FIN |-> !wr_en)
        else $error("table written while result waits");

    a_res_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_FIN |-> res_reg.count <= CNT_W'(CAPACITY))
        else $error("result count above capacity");

endmodule

`default_nettype wire

// ===== rtl/sorted_list_table_top.sv =====
// Throughput: one request in flight, the next taken the cycle after the result is handed
// off; a walk touches one table entry per cycle.
// Reset: entry count cleared, output beat dropped; table contents stay undefined
// and need no clearing pass, since only entries below the count are read.
`default_nettype none

module sorted_list_table_top (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          req_valid,
    output logic               req_stall,
    input  wire slt_pkg::req_beat_t req,
    output logic               rsp_valid,
    input  wire logic          rsp_stall,
    output slt_pkg::rsp_beat_t rsp
);
    import slt_pkg::*;

    logic             busy;
    logic             fin;
    slt_res_t         res;
    logic             start;
    logic             res_ready;
    logic             handoff;
    logic [CNT_W-1:0] count_reg;
    logic             rsp_valid_reg;
    rsp_beat_t        rsp_reg;

    assign req_stall = busy;
    assign start     = req_valid && !busy;
    assign res_ready = !rsp_valid_reg || !rsp_stall;
    assign handoff   = fin && res_ready;

    slt_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .req       (req),
        .count     (count_reg),
        .res_ready (res_ready),
        .busy      (busy),
        .fin       (fin),
        .res       (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (handoff)
            begin
                count_reg     <= res.count;
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (handoff)
        begin
            rsp_reg.status      <= res.status;
            rsp_reg.entry_count <= 5'(res.count);
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        !handoff |=> count_reg == $past(count_reg))
        else $error("count moved without a result");

    a_handoff_slot: assert property (@(posedge clk) disable iff (!rst_n)
        handoff |=> rsp_valid_reg)
        else $error("result lost at output register");

endmodule

`default_nettype wire

// ===== tb/sorted_list_table_top_tb.sv =====
// Testbench for sorted_list_table_top: directed table then phased random requests.
// Depends on slt_pkg and the RTL; results are checked against an in-bench model of the list.
`default_nettype none

module sorted_list_table_top_tb;

    import slt_pkg::*;

    localparam logic [1:0]        KIND_BOGUS = 2'd3;
    localparam logic signed [31:0] VAL_MIN   = 32'sh8000_0000;
    localparam logic signed [31:0] VAL_MAX   = 32'sh7fff_ffff;
    localparam int DIR_N      = 25;
    localparam int RAND_ITEMS = 1025;
    localparam int HANG_LIMIT = 2000;
    localparam int TAIL_WAIT  = 40;

    localparam int MODE_FILL  = 0;
    localparam int MODE_DRAIN = 1;
    localparam int MODE_MIXED = 2;

    typedef struct packed {
        logic [1:0]         kind;
        logic signed [31:0] value;
        bit                 typed;
        logic [1:0]         status;
        logic [4:0]         count;
    } dir_row_t;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       req_valid;
    logic       req_stall;
    req_beat_t  req;
    logic       rsp_valid;
    logic       rsp_stall;
    rsp_beat_t  rsp;

    sorted_list_table_top u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // model of the table contents, updated as each request beat is accepted
    logic signed [31:0] mirror_vals [CAPACITY];
    int                 mirror_cnt = 0;
    rsp_beat_t          awaited_rsp [$];
    int                 errors     = 0;
    int                 hang_cnt   = 0;
    int                 stall_left = 0;
    bit                 quiet      = 1'b0;
    dir_row_t           dir_rows [DIR_N];

    function automatic rsp_beat_t list_apply(req_beat_t b);
        int        pos;
        int        hit;
        rsp_beat_t r;
        r.status = ST_MISS;
        hit = -1;
        for (int k = 0; k < mirror_cnt; k++)
            if (hit < 0 && mirror_vals[k] == b.value)
                hit = k;
        case (b.kind)
            KIND_INSERT:
            begin
                if (mirror_cnt >= CAPACITY)
                    r.status = ST_FULL;
                else
                begin
                    // new value goes in front of any equal entries
                    pos = 0;
                    while (pos < mirror_cnt && b.value > mirror_vals[pos])
                        pos++;
                    for (int k = mirror_cnt; k > pos; k--)
                        mirror_vals[k] = mirror_vals[k-1];
                    mirror_vals[pos] = b.value;
                    mirror_cnt++;
                    r.status = ST_DONE;
                end
            end
            KIND_DELETE:
            begin
                if (hit >= 0)
                begin
                    for (int k = hit; k < mirror_cnt - 1; k++)
                        mirror_vals[k] = mirror_vals[k+1];
                    mirror_cnt--;
                    r.status = ST_DONE;
                end
            end
            KIND_SEARCH:
            begin
                if (hit >= 0)
                    r.status = ST_DONE;
            end
            default:
                r.status = ST_MISS;
        endcase
        r.entry_count = 5'(mirror_cnt);
        return r;
    endfunction

    // idle length: mostly none or short, now and then long
    function automatic int gap_len();
        int r;
        if (quiet)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic signed [31:0] pick_value(bit from_table);
        int r;
        if (from_table && mirror_cnt > 0 && $urandom_range(0, 3) != 0)
            return mirror_vals[$urandom_range(0, mirror_cnt - 1)];
        r = $urandom_range(0, 9);
        if (r < 4)
            return $signed($urandom_range(0, 16)) - 32'sd8;
        if (r < 6)
        begin
            case ($urandom_range(0, 5))
                0:       return VAL_MIN;
                1:       return VAL_MIN + 32'sd1;
                2:       return VAL_MAX;
                3:       return VAL_MAX - 32'sd1;
                4:       return 32'sd0;
                default: return -32'sd1;
            endcase
        end
        return $urandom;
    endfunction

    function automatic logic [1:0] pick_kind(int mode);
        int r;
        r = $urandom_range(0, 99);
        case (mode)
            MODE_FILL:
                return (r < 90) ? KIND_INSERT : (r < 95) ? KIND_SEARCH :
                       (r < 98) ? KIND_DELETE : KIND_BOGUS;
            MODE_DRAIN:
                return (r < 85) ? KIND_DELETE : (r < 93) ? KIND_SEARCH :
                       (r < 97) ? KIND_INSERT : KIND_BOGUS;
            default:
                return (r < 40) ? KIND_INSERT : (r < 70) ? KIND_DELETE :
                       (r < 95) ? KIND_SEARCH : KIND_BOGUS;
        endcase
    endfunction

    // drive one request beat and hold it until accepted; valid stays up for the next
    task automatic send_beat(req_beat_t b);
        int n;
        n = gap_len();
        if (n > 0)
        begin
            req_valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= b;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
    endtask

    task automatic wait_all_results();
        req_valid <= 1'b0;
        @(posedge clk);
        while (awaited_rsp.size() != 0)
            @(posedge clk);
    endtask

    // response side: random stall pattern
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            rsp_stall  <= 1'b1;
            stall_left <= stall_left - 1;
        end
        else if (gap_len() > 0)
        begin
            rsp_stall  <= 1'b1;
            stall_left <= gap_len();
        end
        else
            rsp_stall <= 1'b0;
    end

    // response checker and hang watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((rsp_valid && !rsp_stall) || (req_valid && !req_stall))
                hang_cnt <= 0;
            else
                hang_cnt <= hang_cnt + 1;
            if (hang_cnt >= HANG_LIMIT)
            begin
                $display("%0t: no beat moved for %0d cycles", $time, HANG_LIMIT);
                $display("FAILURE");
                $finish;
            end
            if (rsp_valid && !rsp_stall)
            begin
                if (awaited_rsp.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, got status %0d count %0d",
                             $time, rsp.status, rsp.entry_count);
                    errors++;
                end
                else
                begin
                    if (rsp.status !== awaited_rsp[0].status)
                    begin
                        $display("%0t: status expected %0d, got %0d",
                                 $time, awaited_rsp[0].status, rsp.status);
                        errors++;
                    end
                    if (rsp.entry_count !== awaited_rsp[0].entry_count)
                    begin
                        $display("%0t: entry_count expected %0d, got %0d",
                                 $time, awaited_rsp[0].entry_count, rsp.entry_count);
                        errors++;
                    end
                    void'(awaited_rsp.pop_front());
                end
            end
        end
    end

    initial
    begin
        req_beat_t b;
        rsp_beat_t p;
        int        sent;
        int        plen;
        int        mode;
        int        phase;

        rst_n     <= 1'b0;
        req_valid <= 1'b0;
        req       <= '0;
        rsp_stall <= 1'b0;

        dir_rows = '{
            '{KIND_SEARCH, 32'sd0,          1'b1, ST_MISS, 5'd0},
            '{KIND_DELETE, 32'sd5,          1'b1, ST_MISS, 5'd0},
            '{KIND_BOGUS,  32'sd7,          1'b1, ST_MISS, 5'd0},
            '{KIND_INSERT, VAL_MAX,         1'b1, ST_DONE, 5'd1},
            '{KIND_INSERT, VAL_MIN,         1'b1, ST_DONE, 5'd2},
            '{KIND_INSERT, 32'sd0,          1'b1, ST_DONE, 5'd3},
            '{KIND_INSERT, 32'sd0,          1'b1, ST_DONE, 5'd4},
            '{KIND_SEARCH, VAL_MIN,         1'b1, ST_DONE, 5'd4},
            '{KIND_SEARCH, VAL_MAX,         1'b1, ST_DONE, 5'd4},
            '{KIND_SEARCH, -32'sd1,         1'b1, ST_MISS, 5'd4},
            '{KIND_BOGUS,  VAL_MAX,         1'b1, ST_MISS, 5'd4},
            '{KIND_DELETE, 32'sd0,          1'b1, ST_DONE, 5'd3},
            '{KIND_DELETE, 32'sd0,          1'b1, ST_DONE, 5'd2},
            '{KIND_DELETE, 32'sd0,          1'b1, ST_MISS, 5'd2},
            '{KIND_INSERT, -32'sd1,         1'b0, ST_DONE, 5'd0},
            '{KIND_INSERT, VAL_MIN,         1'b0, ST_DONE, 5'd0},
            '{KIND_DELETE, VAL_MIN,         1'b0, ST_DONE, 5'd0},
            '{KIND_INSERT, 32'sh5555_5555,  1'b0, ST_DONE, 5'd0},
            '{KIND_INSERT, 32'shAAAA_AAAA,  1'b0, ST_DONE, 5'd0},
            '{KIND_SEARCH, 32'sh5555_5555,  1'b0, ST_DONE, 5'd0},
            '{KIND_DELETE, VAL_MAX,         1'b0, ST_DONE, 5'd0},
            '{KIND_INSERT, VAL_MAX,         1'b0, ST_DONE, 5'd0},
            '{KIND_INSERT, 32'sd1,          1'b0, ST_DONE, 5'd0},
            '{KIND_DELETE, -32'sd1,         1'b0, ST_DONE, 5'd0},
            '{KIND_SEARCH, 32'sd1,          1'b0, ST_DONE, 5'd0}
        };

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < DIR_N; i++)
        begin
            b.kind  = dir_rows[i].kind;
            b.value = dir_rows[i].value;
            send_beat(b);
            p = list_apply(b);
            if (dir_rows[i].typed)
            begin
                p.status      = dir_rows[i].status;
                p.entry_count = dir_rows[i].count;
            end
            awaited_rsp.push_back(p);
        end
        wait_all_results();

        // first phase fills the table so full refusals are seen early
        sent  = 0;
        phase = 0;
        while (sent < RAND_ITEMS)
        begin
            mode  = (phase == 0) ? MODE_FILL : $urandom_range(MODE_FILL, MODE_MIXED);
            quiet = ($urandom_range(0, 3) == 0);
            plen  = $urandom_range(30, 80);
            for (int j = 0; j < plen && sent < RAND_ITEMS; j++)
            begin
                b.kind  = pick_kind(mode);
                b.value = pick_value(b.kind == KIND_DELETE || b.kind == KIND_SEARCH);
                send_beat(b);
                awaited_rsp.push_back(list_apply(b));
                sent++;
            end
            wait_all_results();
            phase++;
        end

        quiet = 1'b0;
        repeat (TAIL_WAIT) @(posedge clk);
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

`default_nettype wire
